### sv/hpg_pkg.sv
// Shared types and constants for the hypocycloid point generator.
// Depends on nothing; the CORDIC and the top level refer to it by scoped names.
package hpg_pkg;

  // Register indexes of the configuration port
  localparam logic [2:0] CFG_BIG_RADIUS   = 3'd0;
  localparam logic [2:0] CFG_SMALL_RADIUS = 3'd1;
  localparam logic [2:0] CFG_LOBE_RATIO   = 3'd2;
  localparam logic [2:0] CFG_TURNS        = 3'd3;
  localparam logic [2:0] CFG_TIME_SCALE   = 3'd4;

  // Register reset values
  localparam logic [15:0] BIG_RADIUS_RST   = 16'd9830;
  localparam logic [15:0] SMALL_RADIUS_RST = 16'd3277;
  localparam logic [23:0] LOBE_RATIO_RST   = 24'd131072;
  localparam logic [6:0]  TURNS_RST        = 7'd1;
  localparam logic [23:0] TIME_SCALE_RST   = 24'd65536;

  // CORDIC set-up: gain-compensated start value in Q2.30, angles in Q0.32 turns
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861
  };

  // Output saturation limits, Q3.15
  localparam logic signed [19:0] OUT_MAX = 20'sd262143;
  localparam logic signed [19:0] OUT_MIN = -20'sd262144;

  // Side information that travels with each beat down the pipeline
  typedef struct packed {
    logic vld;
    logic last;
    logic beyond;
  } hpg_side_t;

endpackage

### sv/hpg_if.sv
// Channel interfaces: point index in, curve point out, configuration writes.
// Depends on nothing but plain logic types.
interface hpg_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] point_index;
  modport source (output valid, output point_index, input ready);
  modport sink   (input valid, input point_index, output ready);
endinterface

interface hpg_out_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] x_coord;
  logic signed [18:0] y_coord;
  logic               last_point;
  logic               beyond_end;
  modport source (output valid, output x_coord, output y_coord, output last_point,
                  output beyond_end, input ready);
  modport sink   (input valid, input x_coord, input y_coord, input last_point,
                  input beyond_end, output ready);
endinterface

interface hpg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/hpg_cordic.sv
// Pipelined rotation-mode CORDIC: cosine and sine of a Q0.32 turn angle, Q2.30.
// Depends on hpg_pkg for the arctangent table, gain and step count.
module hpg_cordic (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        angle,
  output logic signed [31:0] cos_q,
  output logic signed [31:0] sin_q
);

  localparam int W = 34;
  localparam int N = hpg_pkg::CORDIC_STEPS;
  localparam logic signed [W-1:0] QTR  = 34'sd1073741824;
  localparam logic signed [W-1:0] HALF = 34'sd2147483648;

  logic signed [W-1:0] x_r [0:N];
  logic signed [W-1:0] y_r [0:N];
  logic signed [W-1:0] z_r [0:N];
  logic                flip_r [0:N];
  logic signed [W-1:0] z_in;
  logic signed [W-1:0] z_nxt;
  logic                flip_nxt;
  logic signed [31:0]  cos_r;
  logic signed [31:0]  sin_r;

  // Fold the angle into the right half-plane and note the half turn.
  always_comb begin
    z_in     = W'($signed(angle));
    z_nxt    = z_in;
    flip_nxt = 1'b0;
    if (z_in > QTR) begin
      z_nxt    = z_in - HALF;
      flip_nxt = 1'b1;
    end else if (z_in < -QTR) begin
      z_nxt    = z_in + HALF;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= $signed(W'(hpg_pkg::CORDIC_GAIN));
      y_r[0]    <= '0;
      z_r[0]    <= z_nxt;
      flip_r[0] <= flip_nxt;
    end
  end

  // One micro-rotation per stage.
  for (genvar k = 0; k < N; k++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[k+1] <= flip_r[k];
        if (!z_r[k][W-1]) begin
          x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] - $signed(W'(hpg_pkg::ATAN_TURNS[k]));
        end else begin
          x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] + $signed(W'(hpg_pkg::ATAN_TURNS[k]));
        end
      end
    end
  end

  // Undo the half-turn fold.
  always_ff @(posedge clk) begin
    if (en) begin
      if (flip_r[N]) begin
        cos_r <= 32'(-x_r[N]);
        sin_r <= 32'(-y_r[N]);
      end else begin
        cos_r <= 32'(x_r[N]);
        sin_r <= 32'(y_r[N]);
      end
    end
  end

  assign cos_q = cos_r;
  assign sin_q = sin_r;

  // z_r of the last stage only steers nothing further; it is kept for the chain.
  logic unused_z;
  assign unused_z = z_r[N][0];

endmodule

### sv/hypocycloid_point_generator_unit.sv
// Top level of the hypocycloid point generator: phase arithmetic, two CORDICs,
// radius products and output rounding. Depends on hpg_pkg, hpg_if, hpg_cordic.
//
//   channel  | dir | beat content
//   ---------+-----+--------------------------------------------------
//   cfg_ch   | in  | index (3 b), data (24 b) register write
//   in_ch    | in  | point_index (16 b)
//   out_ch   | out | x_coord, y_coord (Q3.15), last_point, beyond_end
//
// One beat is accepted per cycle unless the output stalls; a result passes
// through the two phase stages, the 18-stage CORDICs and three product stages.
// Reset clears all valid bits and presets the configuration; no flush needed.
// A stalled output holds the whole pipeline, so nothing is lost or repeated.
// Configuration writes are always taken.
module hypocycloid_point_generator_unit #(
  parameter int POINTS_PER_TURN = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  hpg_cfg_if.sink      cfg_ch,
  hpg_in_if.sink       in_ch,
  hpg_out_if.source    out_ch
);

  // Points per turn must be a power of two (unchecked): the divide is a shift.
  localparam int LOG2_PPT = $clog2(POINTS_PER_TURN);
  localparam int TOT_W    = 7 + LOG2_PPT;
  localparam int CMP_W    = (TOT_W > 16) ? TOT_W : 16;
  localparam int CL       = hpg_pkg::CORDIC_LAT;

  // Configuration registers
  logic [15:0] big_r;
  logic [15:0] small_r;
  logic [23:0] ratio_r;
  logic [6:0]  turns_r;
  logic [23:0] tscale_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_r    <= hpg_pkg::BIG_RADIUS_RST;
      small_r  <= hpg_pkg::SMALL_RADIUS_RST;
      ratio_r  <= hpg_pkg::LOBE_RATIO_RST;
      turns_r  <= hpg_pkg::TURNS_RST;
      tscale_r <= hpg_pkg::TIME_SCALE_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        hpg_pkg::CFG_BIG_RADIUS:   big_r    <= cfg_ch.data[15:0];
        hpg_pkg::CFG_SMALL_RADIUS: small_r  <= cfg_ch.data[15:0];
        hpg_pkg::CFG_LOBE_RATIO:   ratio_r  <= cfg_ch.data;
        hpg_pkg::CFG_TURNS:        turns_r  <= cfg_ch.data[6:0];
        hpg_pkg::CFG_TIME_SCALE:   tscale_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless a finished beat is held at the output.
  logic out_valid_r;
  logic adv;
  logic in_fire;
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign in_fire     = in_ch.valid && adv;

  // Stage 1: time_scale times index, and the end-of-curve flags.
  logic [CMP_W-1:0]   total_w;
  logic [CMP_W-1:0]   idx_w;
  logic [39:0]        tprod_nxt;
  logic [39:0]        tprod_r;
  hpg_pkg::hpg_side_t s1_side_nxt;
  hpg_pkg::hpg_side_t s1_side_r;

  always_comb begin
    total_w            = CMP_W'({turns_r, {LOG2_PPT{1'b0}}});
    idx_w              = CMP_W'(in_ch.point_index);
    tprod_nxt          = tscale_r * in_ch.point_index;
    s1_side_nxt.vld    = in_ch.valid;
    s1_side_nxt.last   = (total_w != '0) && (idx_w == total_w - CMP_W'(1));
    s1_side_nxt.beyond = (idx_w >= total_w);
  end

  // Stage 2: base phase and the two partial products of the lobe phase.
  logic [55:0]        full_w;
  logic [47:0]        full48;
  logic signed [56:0] mlo_full;
  logic signed [40:0] mhi_full;
  logic [31:0]        base_r;
  logic [47:0]        mlo_r;
  logic [15:0]        mhi_r;
  hpg_pkg::hpg_side_t s2_side_r;

  always_comb begin
    full_w   = 56'({tprod_r, 16'b0} >> LOG2_PPT);
    full48   = full_w[47:0];
    mlo_full = $signed(ratio_r) * $signed({1'b0, full48[31:0]});
    mhi_full = $signed(ratio_r) * $signed({1'b0, full48[47:32]});
  end

  // Lobe phase: bits 16 to 47 of the ratio times the full phase.
  logic [31:0] lobe_w;
  assign lobe_w = mlo_r[47:16] + {mhi_r, 16'b0};

  // Sine and cosine of both phases
  logic signed [31:0] cb_w;
  logic signed [31:0] sb_w;
  logic signed [31:0] cl_w;
  logic signed [31:0] sl_w;

  hpg_cordic u_cordic_base (
    .clk   (clk),
    .en    (adv),
    .angle (base_r),
    .cos_q (cb_w),
    .sin_q (sb_w)
  );

  hpg_cordic u_cordic_lobe (
    .clk   (clk),
    .en    (adv),
    .angle (lobe_w),
    .cos_q (cl_w),
    .sin_q (sl_w)
  );

  hpg_pkg::hpg_side_t side_pipe_r [0:CL-1];

  // Radius products, sums and output register
  logic signed [16:0] d_w;
  logic signed [16:0] r_w;
  logic signed [48:0] pxb_r;
  logic signed [48:0] pxl_r;
  logic signed [48:0] pyb_r;
  logic signed [48:0] pyl_r;
  hpg_pkg::hpg_side_t mul_side_r;
  logic signed [49:0] accx_r;
  logic signed [49:0] accy_r;
  hpg_pkg::hpg_side_t acc_side_r;

  assign d_w = $signed({1'b0, big_r}) - $signed({1'b0, small_r});
  assign r_w = $signed({1'b0, small_r});

  // Rounding half up to Q.15 and saturation to 19 bits.
  logic signed [49:0] rx_w;
  logic signed [49:0] ry_w;
  logic signed [19:0] sx_w;
  logic signed [19:0] sy_w;
  logic signed [18:0] x_nxt;
  logic signed [18:0] y_nxt;

  always_comb begin
    rx_w = accx_r + 50'sd536870912;
    ry_w = accy_r + 50'sd536870912;
    sx_w = 20'(rx_w >>> 30);
    sy_w = 20'(ry_w >>> 30);
    if ((rx_w >>> 30) > 50'(hpg_pkg::OUT_MAX)) begin
      x_nxt = 19'(hpg_pkg::OUT_MAX);
    end else if ((rx_w >>> 30) < 50'(hpg_pkg::OUT_MIN)) begin
      x_nxt = 19'(hpg_pkg::OUT_MIN);
    end else begin
      x_nxt = sx_w[18:0];
    end
    if ((ry_w >>> 30) > 50'(hpg_pkg::OUT_MAX)) begin
      y_nxt = 19'(hpg_pkg::OUT_MAX);
    end else if ((ry_w >>> 30) < 50'(hpg_pkg::OUT_MIN)) begin
      y_nxt = 19'(hpg_pkg::OUT_MIN);
    end else begin
      y_nxt = sy_w[18:0];
    end
  end

  logic signed [18:0] x_r;
  logic signed [18:0] y_r;
  logic               last_r;
  logic               beyond_r;

  // Payload registers of all stages
  always_ff @(posedge clk) begin
    if (adv) begin
      tprod_r  <= tprod_nxt;
      base_r   <= full48[31:0];
      mlo_r    <= mlo_full[47:0];
      mhi_r    <= mhi_full[15:0];
      pxb_r    <= d_w * cb_w;
      pxl_r    <= r_w * cl_w;
      pyb_r    <= d_w * sb_w;
      pyl_r    <= r_w * sl_w;
      accx_r   <= 50'(pxb_r) + 50'(pxl_r);
      accy_r   <= 50'(pyb_r) - 50'(pyl_r);
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      last_r   <= acc_side_r.last;
      beyond_r <= acc_side_r.beyond;
    end
  end

  // Side information and valid bits, aligned with the data stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r   <= '0;
      s2_side_r   <= '0;
      mul_side_r  <= '0;
      acc_side_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CL; i++) begin
        side_pipe_r[i] <= '0;
      end
    end else if (adv) begin
      s1_side_r      <= s1_side_nxt;
      s2_side_r      <= s1_side_r;
      side_pipe_r[0] <= s2_side_r;
      for (int i = 1; i < CL; i++) begin
        side_pipe_r[i] <= side_pipe_r[i-1];
      end
      mul_side_r  <= side_pipe_r[CL-1];
      acc_side_r  <= mul_side_r;
      out_valid_r <= acc_side_r.vld;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.x_coord    = x_r;
  assign out_ch.y_coord    = y_r;
  assign out_ch.last_point = last_r;
  assign out_ch.beyond_end = beyond_r;

  // Checks
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.last_point && out_ch.beyond_end))
    else $error("last_point and beyond_end both set");

  a_stall_holds_x: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !adv) |=> $stable(out_ch.x_coord) && out_valid_r)
    else $error("result changed while stalled");

  a_entry_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_side_r.vld)
    else $error("accepted beat lost its valid bit");

endmodule
